@@ rtl/pfde_pkg.sv @@
`default_nettype none
package pfde_pkg;
	localparam int COLUMNS = 128;
	localparam int ROWS = 64;
	localparam int PAGES = (ROWS + 7) / 8;
	localparam int STORE_BYTES = COLUMNS * PAGES;
	localparam int AW = $clog2(STORE_BYTES);
	localparam int PW = $clog2(PAGES);
	localparam int CW = $clog2(COLUMNS);

	typedef enum logic [2:0] {
		OP_FILL  = 3'd0,
		OP_POINT = 3'd1,
		OP_LINE  = 3'd2,
		OP_PIC   = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_DIV,
		ST_PLOT,
		ST_RD,
		ST_WR,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture the beat
		logic fill_init; // start fill sweep
		logic fill_step; // write one fill byte, advance
		logic div_init;  // start DDA division
		logic div_step;  // one quotient bit
		logic pix_rd;    // address store for current pixel
		logic pix_wr;    // write modified byte, advance pixel
		logic finish;    // present result, update picture cursor
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fill_last;
		logic div_last;
		logic pix_last;
		logic line_empty;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/pfde_ctrl.sv @@
`default_nettype none
module pfde_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire [2:0]       operation,
	input  pfde_pkg::sts_t  sts,
	output logic            busy,
	output pfde_pkg::cmd_t  cmd
);
	import pfde_pkg::*;

	state_t state_q, state_d;

	// Hold state; clear the store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	// Sequence each operation
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (operation)
						OP_FILL: begin
							cmd.fill_init = 1'b1;
							state_d = ST_FILL;
						end
						OP_LINE: begin
							cmd.div_init = 1'b1;
							state_d = ST_DIV;
						end
						OP_POINT, OP_PIC, OP_READ: state_d = ST_RD;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) state_d = ST_DONE;
			end
			ST_DIV: begin
				if (sts.line_empty) state_d = ST_DONE;
				else begin
					cmd.div_step = 1'b1;
					if (sts.div_last) state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.pix_rd = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.pix_wr = 1'b1;
				state_d = sts.pix_last ? ST_DONE : ST_RD;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTH
	a_fill_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && !sts.fill_last) |=> state_q == ST_FILL)
		else $error("fill sweep left early");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> state_q == ST_IDLE)
		else $error("done not followed by idle");
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> state_q == ST_WR)
		else $error("read not followed by write");
`endif
endmodule
`default_nettype wire

@@ rtl/pfde_dp.sv @@
`default_nettype none
module pfde_dp (
	input  wire             clk,
	input  wire             arst_n,
	input  pfde_pkg::cmd_t  cmd,
	input  wire [2:0]       operation,
	input  wire [6:0]       x_start,
	input  wire [5:0]       y_start,
	input  wire [7:0]       x_end,
	input  wire [5:0]       y_end,
	input  wire             pixel_value,
	input  wire [7:0]       picture_byte,
	input  wire             first_byte,
	input  wire [2:0]       read_page,
	output pfde_pkg::sts_t  sts,
	output logic            done,
	output logic [7:0]      read_data,
	output logic            clipped
);
	import pfde_pkg::*;

	logic [7:0]  mem [STORE_BYTES];
	logic [7:0]  rdata_q;

	op_t         op_q;
	logic [6:0]  xs_q;
	logic [5:0]  ys_q;
	logic [7:0]  xe_q;
	logic [2:0]  pg_q;
	logic        pv_q;
	logic [7:0]  pb_q;
	logic        clip_q;
	logic [7:0]  pcol_q;
	logic [3:0]  prow_q;
	logic [AW-1:0] fill_q;

	// Line state: signs, divider, positions
	logic [7:0]  dm_q;
	logic        sgx_q, sgy_q;
	logic [23:0] rx_q, ry_q, qx_q, qy_q;
	logic [4:0]  dcnt_q;
	logic [24:0] px_q, py_q;
	logic [7:0]  cnt_q;
	logic [2:0]  bit_q;

	// Line deltas at load
	logic signed [8:0] ddx, ddy;
	logic [7:0] alx, aly;
	assign ddx = $signed({1'b0, x_end}) - $signed({2'b0, x_start});
	assign ddy = $signed({3'b0, y_end}) - $signed({3'b0, y_start});
	assign alx = ddx[8] ? 8'(-ddx) : ddx[7:0];
	assign aly = ddy[8] ? 8'(-ddy) : ddy[7:0];

	// Restoring division step, numerator = mag << 16
	logic [24:0] tx, ty;
	assign tx = {rx_q, qx_q[23]} - {17'b0, dm_q};
	assign ty = {ry_q, qy_q[23]} - {17'b0, dm_q};

	// Current pixel coordinates
	logic [15:0] pcx, pcy;
	logic [7:0]  pic_r;
	always_comb begin
		pcx = 16'hffff;
		pcy = 16'hffff;
		pic_r = 8'(ys_q) + {1'b0, prow_q, 3'b0} + 8'(bit_q);
		case (op_q)
			OP_POINT: begin
				pcx = 16'(xs_q);
				pcy = 16'(ys_q);
			end
			OP_LINE: begin
				if (!px_q[24]) pcx = 16'(px_q[23:16]);
				if (!py_q[24]) pcy = 16'(py_q[23:16]);
			end
			OP_PIC: begin
				pcx = 16'({xs_q} + 9'(pcol_q));
				pcy = 16'(pic_r);
			end
			OP_READ: begin
				pcx = 16'(xs_q);
				pcy = {10'b0, pg_q, 3'b0};
			end
			default: ;
		endcase
	end

	logic inb;
	logic [AW-1:0] paddr;
	logic pval;
	assign inb = (pcx < 16'(COLUMNS)) && (pcy < 16'(ROWS));
	assign paddr = AW'(pcx[CW-1:0] * PAGES) + AW'(pcy[15:3]);
	always_comb begin
		case (op_q)
			OP_POINT: pval = pv_q;
			OP_PIC:   pval = pb_q[bit_q] ? pv_q : ~pv_q;
			default:  pval = 1'b1;
		endcase
	end
	logic [7:0] bmask;
	assign bmask = 8'd1 << pcy[2:0];

	assign sts.fill_last = (fill_q == AW'(STORE_BYTES - 1));
	assign sts.div_last = (dcnt_q == 5'd23);
	assign sts.line_empty = (dm_q == 8'd0);
	assign sts.pix_last = (op_q == OP_LINE) ? (cnt_q == dm_q - 8'd1) :
		(op_q == OP_PIC) ? (bit_q == 3'd7) : 1'b1;

	logic [7:0] pnext;
	assign pnext = pcol_q + 8'd1;

	// Store: fill sweep, read-modify-write, read back
	always_ff @(posedge clk) begin
		if (cmd.fill_step) mem[fill_q] <= {8{pv_q}};
		if (cmd.pix_rd) rdata_q <= mem[paddr];
		if (cmd.pix_wr && inb && op_q != OP_READ)
			mem[paddr] <= pval ? (rdata_q | bmask) : (rdata_q & ~bmask);
	end

	// Control registers and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_FILL;
			xs_q <= '0;
			ys_q <= '0;
			xe_q <= '0;
			pg_q <= '0;
			pv_q <= 1'b0;
			pb_q <= '0;
			pcol_q <= '0;
			prow_q <= '0;
			clip_q <= 1'b0;
			done <= 1'b0;
			read_data <= '0;
			clipped <= 1'b0;
			fill_q <= '0;
			dm_q <= '0;
			sgx_q <= 1'b0;
			sgy_q <= 1'b0;
			rx_q <= '0;
			ry_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			px_q <= '0;
			py_q <= '0;
			cnt_q <= '0;
			bit_q <= '0;
			dcnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (cmd.load) begin
				op_q <= op_t'(operation);
				xs_q <= x_start;
				ys_q <= y_start;
				xe_q <= x_end;
				pg_q <= read_page;
				pv_q <= pixel_value;
				pb_q <= picture_byte;
				clip_q <= 1'b0;
				cnt_q <= '0;
				bit_q <= '0;
				fill_q <= '0;
				if (operation == OP_PIC && first_byte) begin
					pcol_q <= '0;
					prow_q <= '0;
				end
				if (operation == OP_LINE) begin
					sgx_q <= ddx[8];
					sgy_q <= ddy[8];
					dm_q <= (alx >= aly) ? alx : aly;
					rx_q <= '0;
					ry_q <= '0;
					qx_q <= {alx, 16'b0};
					qy_q <= {aly, 16'b0};
					dcnt_q <= '0;
					px_q <= {2'b0, x_start, 16'h8000};
					py_q <= {3'b0, y_start, 16'h8000};
				end else begin
					dm_q <= 8'd1;
				end
			end
			if (cmd.fill_step) fill_q <= fill_q + AW'(1);
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 5'd1;
				if (!tx[24]) rx_q <= tx[23:0];
				else rx_q <= {rx_q[22:0], qx_q[23]};
				qx_q <= {qx_q[22:0], ~tx[24]};
				if (!ty[24]) ry_q <= ty[23:0];
				else ry_q <= {ry_q[22:0], qy_q[23]};
				qy_q <= {qy_q[22:0], ~ty[24]};
			end
			if (cmd.pix_wr) begin
				if (op_q == OP_READ) begin
					if (!inb) clip_q <= 1'b1;
				end else if (!inb) clip_q <= 1'b1;
				cnt_q <= cnt_q + 8'd1;
				bit_q <= bit_q + 3'd1;
				px_q <= sgx_q ? px_q - {1'b0, qx_q} : px_q + {1'b0, qx_q};
				py_q <= sgy_q ? py_q - {1'b0, qy_q} : py_q + {1'b0, qy_q};
			end
			if (cmd.finish) begin
				done <= 1'b1;
				clipped <= clip_q;
				read_data <= (op_q == OP_READ && !clip_q) ? rdata_q : 8'd0;
				if (op_q == OP_PIC) begin
					if (pnext == xe_q) begin
						pcol_q <= '0;
						prow_q <= prow_q + 4'd1;
					end else pcol_q <= pnext;
				end
			end
		end
	end

`ifndef SYNTH
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped && op_q == OP_READ) |-> read_data == 8'd0)
		else $error("clipped read returned data");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= 5'd24)
		else $error("divider overran");
`endif
endmodule
`default_nettype wire

@@ rtl/page_framebuffer_draw_engine.sv @@
`default_nettype none
// Draw engine over a 128x64 monochrome page store (byte = 8 vertical pixels).
// Assert start while busy is low; one result appears with done high for one
// cycle, and it cannot be stalled. After reset the engine clears the store one
// byte per cycle and holds busy high until it is clear. Fill writes one byte
// per cycle. Point does one store read-modify-write, picture-byte eight (one
// per bit) and read one store read. Line first runs the divider for 24
// quotient bits, then does one read-modify-write per plotted pixel, up to 255
// pixels.
module page_framebuffer_draw_engine (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire [2:0]  operation,
	input  wire [6:0]  x_start,
	input  wire [5:0]  y_start,
	input  wire [7:0]  x_end,
	input  wire [5:0]  y_end,
	input  wire        pixel_value,
	input  wire [7:0]  picture_byte,
	input  wire        first_byte,
	input  wire [2:0]  read_page,
	output logic       done,
	output logic [7:0] read_data,
	output logic       clipped
);
	import pfde_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pfde_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	pfde_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .operation(operation),
		.x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
		.pixel_value(pixel_value), .picture_byte(picture_byte),
		.first_byte(first_byte), .read_page(read_page), .sts(sts),
		.done(done), .read_data(read_data), .clipped(clipped)
	);
endmodule
`default_nettype wire
